// ===== hdl/tldf_pkg.sv =====
package tldf_pkg;

   localparam int TICK_W    = 48;
   localparam int PAYLOAD_W = 64;
   localparam int CFG_W     = 16;
   localparam int OCC_W     = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEQ_SPACING  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_LATENCY = 1'd1;

   localparam logic [CFG_W-1:0] DEQ_SPACING_RST  = 16'd1;
   localparam logic [CFG_W-1:0] LINK_LATENCY_RST = 16'd4;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_PUSH = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } ctrl_state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/tldf_req_if.sv =====
interface tldf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [tldf_pkg::TICK_W-1:0]      current_tick;
   logic [tldf_pkg::PAYLOAD_W-1:0]   flit_payload;
   logic [tldf_pkg::TICK_W-1:0]      transmit_tick;

   modport source (
      output valid, action, current_tick, flit_payload, transmit_tick,
      input  ready
   );

   modport sink (
      input  valid, action, current_tick, flit_payload, transmit_tick,
      output ready
   );
endinterface

// ===== hdl/tldf_rsp_if.sv =====
interface tldf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             delivered;
   logic [tldf_pkg::PAYLOAD_W-1:0]   out_payload;
   logic [tldf_pkg::TICK_W-1:0]      receive_tick;
   logic [tldf_pkg::OCC_W-1:0]       occupancy;
   logic                             link_full;
   logic                             stagnant;
   logic                             rejected;

   modport source (
      output valid, delivered, out_payload, receive_tick, occupancy, link_full,
             stagnant, rejected,
      input  ready
   );

   modport sink (
      input  valid, delivered, out_payload, receive_tick, occupancy, link_full,
             stagnant, rejected,
      output ready
   );
endinterface

// ===== hdl/timed_link_delay_fifo.sv =====
// Channel  Ports              Dir  Contents
// req      req_ch.*           in   action, current_tick, flit_payload, transmit_tick
// rsp      rsp_ch.*           out  delivered, out_payload, receive_tick, occupancy,
//                                  link_full, stagnant, rejected
// csr      csr_we/index/wdata in   index 0 = dequeue spacing, index 1 = link delay
//
// A transaction is accepted in ST_IDLE with the registered read of the head slot, then
// evaluated and committed into the result register in ST_EVAL.
// A new request is taken while the previous result still waits in the result register.
// A result that is not taken stalls the evaluation cycle, not the register state.
// Reset is synchronous; slot storage is not cleared, only pointers, count, timer, result valid, CSRs and state.
module timed_link_delay_fifo #(
   parameter int LINK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   tldf_req_if.sink                       req_ch,
   tldf_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [tldf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tldf_pkg::CFG_W-1:0]     csr_wdata
);

   tldf_pkg::ctrl_cmd_type  cmd;
   tldf_pkg::dp_status_type status;

   tldf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   tldf_datapath #(
      .LINK_DEPTH (LINK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hdl/tldf_ctrl.sv =====
module tldf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  tldf_pkg::dp_status_type status,
   output tldf_pkg::ctrl_cmd_type  cmd
);

   tldf_pkg::ctrl_state_type state_ff;
   tldf_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tldf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tldf_pkg::ST_IDLE: begin
            if (req_valid) state_in = tldf_pkg::ST_EVAL;
         end
         tldf_pkg::ST_EVAL: begin
            if (status.out_free) state_in = tldf_pkg::ST_IDLE;
         end
         default: begin
            state_in = tldf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         tldf_pkg::ST_IDLE: begin
            cmd.ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         tldf_pkg::ST_EVAL: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/tldf_datapath.sv =====
module tldf_datapath #(
   parameter int LINK_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tldf_req_if.sink                              req,
   tldf_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [tldf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tldf_pkg::CFG_W-1:0]            csr_wdata,
   input  tldf_pkg::ctrl_cmd_type                cmd,
   output tldf_pkg::dp_status_type               status
);

   localparam int PTR_W = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
   localparam int CNT_W = $clog2(LINK_DEPTH + 1);
   localparam int TW    = tldf_pkg::TICK_W;
   localparam int PW    = tldf_pkg::PAYLOAD_W;

   logic [tldf_pkg::CFG_W-1:0] tpd_ff;
   logic [tldf_pkg::CFG_W-1:0] lat_ff;

   logic          act_ff;
   logic [TW-1:0] now_ff;
   logic [PW-1:0] pay_ff;
   logic [TW-1:0] txt_ff;

   logic [PW-1:0] slot_payload_ff [LINK_DEPTH];
   logic [TW-1:0] slot_transmit_ff [LINK_DEPTH];
   logic [PW-1:0] head_pay_ff;
   logic [TW-1:0] head_txt_ff;

   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TW-1:0]    last_deq_ff, last_deq_in;

   logic                      rsp_valid_ff;
   logic                      rsp_deliv_ff, rsp_deliv_in;
   logic [PW-1:0]             rsp_pay_ff, rsp_pay_in;
   logic [TW-1:0]             rsp_rx_ff, rsp_rx_in;
   logic [tldf_pkg::OCC_W-1:0] rsp_occ_ff;
   logic                      rsp_full_ff;
   logic                      rsp_stag_ff, rsp_stag_in;
   logic                      rsp_rej_ff, rsp_rej_in;

   logic          is_full, link_empty, do_push;
   logic [TW-1:0] age, since_deq;
   logic          age_ok, since_ok, lat_reached, lat_exceeded, spacing_reached;

   assign req.ready       = cmd.ready;
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpd_ff <= tldf_pkg::DEQ_SPACING_RST;
         lat_ff <= tldf_pkg::LINK_LATENCY_RST;
      end else if (csr_we) begin
         if (csr_index == tldf_pkg::CSR_DEQ_SPACING)  tpd_ff <= csr_wdata;
         if (csr_index == tldf_pkg::CSR_LINK_LATENCY) lat_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff      <= req.action;
         now_ff      <= req.current_tick;
         pay_ff      <= req.flit_payload;
         txt_ff      <= req.transmit_tick;
         head_pay_ff <= slot_payload_ff[head_ptr_ff];
         head_txt_ff <= slot_transmit_ff[head_ptr_ff];
      end
      if (do_push) begin
         slot_payload_ff[tail_ptr_ff]  <= pay_ff;
         slot_transmit_ff[tail_ptr_ff] <= txt_ff;
      end
   end

   assign is_full    = (count_ff == CNT_W'(LINK_DEPTH));
   assign link_empty = (count_ff == '0);
   assign do_push    = cmd.commit && (act_ff == tldf_pkg::ACTION_PUSH) && !is_full;

   assign age             = now_ff - head_txt_ff;
   assign since_deq       = now_ff - last_deq_ff;
   assign age_ok          = (now_ff >= head_txt_ff);
   assign since_ok        = (now_ff >= last_deq_ff);
   assign lat_reached     = age_ok && (age >= TW'(lat_ff));
   assign lat_exceeded    = age_ok && (age > TW'(lat_ff));
   assign spacing_reached = since_ok && (since_deq >= TW'(tpd_ff));

   always_comb begin
      head_ptr_in  = head_ptr_ff;
      tail_ptr_in  = tail_ptr_ff;
      count_in     = count_ff;
      last_deq_in  = last_deq_ff;
      rsp_deliv_in = 1'b0;
      rsp_pay_in   = '0;
      rsp_rx_in    = '0;
      rsp_stag_in  = 1'b0;
      rsp_rej_in   = 1'b0;
      if (act_ff == tldf_pkg::ACTION_PUSH) begin
         if (is_full) begin
            rsp_rej_in = 1'b1;
         end else begin
            if (link_empty) last_deq_in = now_ff;
            tail_ptr_in = (tail_ptr_ff == PTR_W'(LINK_DEPTH - 1)) ? '0 : tail_ptr_ff + 1'b1;
            count_in    = count_ff + 1'b1;
         end
      end else if (!link_empty) begin
         rsp_stag_in = lat_exceeded;
         if (spacing_reached && lat_reached) begin
            rsp_deliv_in = 1'b1;
            rsp_pay_in   = head_pay_ff;
            rsp_rx_in    = now_ff;
            head_ptr_in  = (head_ptr_ff == PTR_W'(LINK_DEPTH - 1)) ? '0 : head_ptr_ff + 1'b1;
            count_in     = count_ff - 1'b1;
            last_deq_in  = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         count_ff     <= '0;
         last_deq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            head_ptr_ff  <= head_ptr_in;
            tail_ptr_ff  <= tail_ptr_in;
            count_ff     <= count_in;
            last_deq_ff  <= last_deq_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_deliv_ff <= rsp_deliv_in;
         rsp_pay_ff   <= rsp_pay_in;
         rsp_rx_ff    <= rsp_rx_in;
         rsp_occ_ff   <= tldf_pkg::OCC_W'(count_in);
         rsp_full_ff  <= (count_in == CNT_W'(LINK_DEPTH));
         rsp_stag_ff  <= rsp_stag_in;
         rsp_rej_ff   <= rsp_rej_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.delivered    = rsp_deliv_ff;
   assign rsp.out_payload  = rsp_pay_ff;
   assign rsp.receive_tick = rsp_rx_ff;
   assign rsp.occupancy    = rsp_occ_ff;
   assign rsp.link_full    = rsp_full_ff;
   assign rsp.stagnant     = rsp_stag_ff;
   assign rsp.rejected     = rsp_rej_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LINK_DEPTH))
      else $error("flit count above link depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the link");

   a_rej_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rej_ff |-> !rsp_deliv_ff && !rsp_stag_ff)
      else $error("rejected push reported delivery or stagnation");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || rsp.ready)
      else $error("result overwritten before it was taken");

endmodule
